>>> rtl/brq_pkg.sv
package brq_pkg;

	localparam int ANG_STAGES = 12;
	localparam int DIST_W = 32;

	localparam logic [29:0] TAN_ONE = 30'd1000000000;
	localparam logic [5:0] FIRST_CAND = 6'd32;
	localparam logic [5:0] TAN_LAST = 6'd44;
	localparam logic [6:0] ANG_MAX = 7'd89;

	localparam logic [8:0] BRG_NORTH = 9'd0;
	localparam logic [8:0] BRG_EAST = 9'd90;
	localparam logic [8:0] BRG_SOUTH = 9'd180;
	localparam logic [8:0] BRG_WEST = 9'd270;
	localparam logic [8:0] BRG_FULL = 9'd360;
	localparam logic [8:0] SECTOR_DEG = 9'd30;

	localparam logic [3:0] HOUR_NORTH = 4'd12;
	localparam logic [3:0] HOUR_SAME = 4'd13;
	localparam logic [3:0] BUCKET_NEAR = 4'd10;
	localparam logic [16:0] RANGE_SAT = 17'h1FFFF;

	localparam logic [7:0] BUCKET_LIM [10] = '{
		8'd200, 8'd150, 8'd100, 8'd75, 8'd50, 8'd25, 8'd15, 8'd10, 8'd5, 8'd1
	};

	typedef struct packed {
		logic xneg;
		logic yneg;
		logic xzero;
		logic yzero;
	} dir_t;

	// tan(k degrees) scaled by 1e9
	function automatic logic [29:0] tan9(input logic [5:0] k);
		logic [29:0] t;
		case (k)
			6'd0: t = 30'd0;
			6'd1: t = 30'd17455065;
			6'd2: t = 30'd34920769;
			6'd3: t = 30'd52407779;
			6'd4: t = 30'd69926812;
			6'd5: t = 30'd87488664;
			6'd6: t = 30'd105104235;
			6'd7: t = 30'd122784561;
			6'd8: t = 30'd140540835;
			6'd9: t = 30'd158384440;
			6'd10: t = 30'd176326981;
			6'd11: t = 30'd194380309;
			6'd12: t = 30'd212556562;
			6'd13: t = 30'd230868191;
			6'd14: t = 30'd249328003;
			6'd15: t = 30'd267949192;
			6'd16: t = 30'd286745386;
			6'd17: t = 30'd305730681;
			6'd18: t = 30'd324919696;
			6'd19: t = 30'd344327613;
			6'd20: t = 30'd363970234;
			6'd21: t = 30'd383864035;
			6'd22: t = 30'd404026226;
			6'd23: t = 30'd424474816;
			6'd24: t = 30'd445228685;
			6'd25: t = 30'd466307658;
			6'd26: t = 30'd487732589;
			6'd27: t = 30'd509525449;
			6'd28: t = 30'd531709432;
			6'd29: t = 30'd554309051;
			6'd30: t = 30'd577350269;
			6'd31: t = 30'd600860619;
			6'd32: t = 30'd624869352;
			6'd33: t = 30'd649407593;
			6'd34: t = 30'd674508517;
			6'd35: t = 30'd700207538;
			6'd36: t = 30'd726542528;
			6'd37: t = 30'd753554050;
			6'd38: t = 30'd781285627;
			6'd39: t = 30'd809784033;
			6'd40: t = 30'd839099631;
			6'd41: t = 30'd869286738;
			6'd42: t = 30'd900404044;
			6'd43: t = 30'd932515086;
			6'd44: t = 30'd965688775;
			6'd45: t = 30'd1000000000;
			default: t = 30'd0;
		endcase
		return t;
	endfunction

	function automatic logic [3:0] hour_of(input logic [8:0] brg, input logic same);
		logic [3:0] h;
		h = 4'd0;
		for (int k = 1; k <= 11; k++) begin
			if (brg >= 9'(30 * k)) begin
				h = h + 4'd1;
			end
		end
		if (same) begin
			h = HOUR_SAME;
		end else if (brg < SECTOR_DEG || brg >= BRG_FULL) begin
			h = HOUR_NORTH;
		end
		return h;
	endfunction

	function automatic logic [3:0] bucket_of(input logic [DIST_W-1:0] d);
		logic [3:0] b;
		b = BUCKET_NEAR;
		for (int i = 9; i >= 0; i--) begin
			if (d > DIST_W'(BUCKET_LIM[i])) begin
				b = 4'(i);
			end
		end
		return b;
	endfunction

endpackage

>>> rtl/brq_front.sv
module brq_front #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic [2:0]                    load,
	input  logic signed [COORD_BITS-1:0]  origin_x,
	input  logic signed [COORD_BITS-1:0]  origin_y,
	input  logic signed [COORD_BITS-1:0]  target_x,
	input  logic signed [COORD_BITS-1:0]  target_y,
	output logic [2*COORD_BITS+1:0]       sumsq,
	output logic [COORD_BITS+30:0]        ps,
	output logic [COORD_BITS+30:0]        pb,
	output logic [COORD_BITS:0]           big,
	output logic                          caseb,
	output brq_pkg::dir_t                 dir
);

	localparam int AW = COORD_BITS + 1;
	localparam int NW = 2 * AW;
	localparam int PW = AW + 30;

	logic [AW-1:0] dx, dy, ax, ay;

	logic [AW-1:0] ax_s1, ay_s1;
	brq_pkg::dir_t dir_s1;

	logic [NW-1:0] sqx_s2, sqy_s2;
	logic [AW-1:0] small_s2, big_s2;
	logic caseb_s2;
	brq_pkg::dir_t dir_s2;

	logic [NW-1:0] n_s3;
	logic [PW-1:0] ps_s3, pb_s3;
	logic [AW-1:0] big_s3;
	logic caseb_s3;
	brq_pkg::dir_t dir_s3;

	assign dx = {target_x[COORD_BITS-1], target_x} - {origin_x[COORD_BITS-1], origin_x};
	assign dy = {target_y[COORD_BITS-1], target_y} - {origin_y[COORD_BITS-1], origin_y};
	assign ax = dx[AW-1] ? (~dx + AW'(1)) : dx;
	assign ay = dy[AW-1] ? (~dy + AW'(1)) : dy;

	always_ff @(posedge clk) begin
		if (load[0]) begin
			ax_s1 <= ax;
			ay_s1 <= ay;
			dir_s1.xneg <= dx[AW-1];
			dir_s1.yneg <= dy[AW-1];
			dir_s1.xzero <= (dx == '0);
			dir_s1.yzero <= (dy == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (load[1]) begin
			sqx_s2 <= NW'(ax_s1) * NW'(ax_s1);
			sqy_s2 <= NW'(ay_s1) * NW'(ay_s1);
			caseb_s2 <= (ax_s1 >= ay_s1);
			small_s2 <= (ax_s1 >= ay_s1) ? ay_s1 : ax_s1;
			big_s2 <= (ax_s1 >= ay_s1) ? ax_s1 : ay_s1;
			dir_s2 <= dir_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load[2]) begin
			n_s3 <= sqx_s2 + sqy_s2;
			ps_s3 <= PW'(small_s2) * PW'(brq_pkg::TAN_ONE);
			pb_s3 <= PW'(big_s2) * PW'(brq_pkg::tan9(brq_pkg::FIRST_CAND));
			big_s3 <= big_s2;
			caseb_s3 <= caseb_s2;
			dir_s3 <= dir_s2;
		end
	end

	assign sumsq = n_s3;
	assign ps = ps_s3;
	assign pb = pb_s3;
	assign big = big_s3;
	assign caseb = caseb_s3;
	assign dir = dir_s3;

endmodule

>>> rtl/brq_angle.sv
module brq_angle #(
	parameter int COORD_BITS = 16,
	parameter int STAGES = 17
) (
	input  logic                    clk,
	input  logic [STAGES-1:0]       load,
	input  logic [COORD_BITS+30:0]  ps_in,
	input  logic [COORD_BITS+30:0]  pb_in,
	input  logic [COORD_BITS:0]     big_in,
	input  logic                    caseb_in,
	input  brq_pkg::dir_t           dir_in,
	output logic [8:0]              bearing,
	output logic                    same
);

	localparam int AW = COORD_BITS + 1;
	localparam int PW = AW + 30;
	localparam int BRG_STAGE = brq_pkg::ANG_STAGES - 1;

	typedef struct packed {
		logic [PW-1:0] ps;
		logic [AW-1:0] big;
		logic caseb;
		logic [5:0] c;
		logic [5:0] cand;
		brq_pkg::dir_t dir;
	} carry_t;

	carry_t head;
	carry_t cmp_s [6];
	logic [29:0] tval_s [5];
	carry_t mul_s [5];
	logic [PW-1:0] pb_s [5];

	logic [6:0] f;
	logic [8:0] brg;
	logic [8:0] brg_s [BRG_STAGE:STAGES-1];
	logic same_s [BRG_STAGE:STAGES-1];

	always_comb begin
		head.ps = ps_in;
		head.big = big_in;
		head.caseb = caseb_in;
		head.c = 6'd0;
		head.cand = brq_pkg::FIRST_CAND;
		head.dir = dir_in;
	end

	// binary search for the count of tangent steps below the angle
	for (genvar j = 0; j < 6; j++) begin : g_cmp
		localparam logic [5:0] STEP = 6'(32 >> (j + 1));
		carry_t cin, nxt;
		logic [PW-1:0] pbin;
		logic ok;

		if (j == 0) begin : g_head
			assign cin = head;
			assign pbin = pb_in;
		end else begin : g_chain
			assign cin = mul_s[j-1];
			assign pbin = pb_s[j-1];
		end

		always_comb begin
			ok = (cin.cand <= brq_pkg::TAN_LAST) &&
				(cin.caseb ? (cin.ps > pbin) : (cin.ps >= pbin));
			nxt = cin;
			if (ok) begin
				nxt.c = cin.cand;
			end
			nxt.cand = nxt.c + STEP;
		end

		always_ff @(posedge clk) begin
			if (load[2*j]) begin
				cmp_s[j] <= nxt;
			end
		end

		if (j < 5) begin : g_tval
			always_ff @(posedge clk) begin
				if (load[2*j]) begin
					tval_s[j] <= brq_pkg::tan9(nxt.cand);
				end
			end
		end
	end

	for (genvar j = 0; j < 5; j++) begin : g_mul
		always_ff @(posedge clk) begin
			if (load[2*j+1]) begin
				mul_s[j] <= cmp_s[j];
				pb_s[j] <= PW'(cmp_s[j].big) * PW'(tval_s[j]);
			end
		end
	end

	always_comb begin
		f = cmp_s[5].caseb ? (brq_pkg::ANG_MAX - 7'(cmp_s[5].c)) : 7'(cmp_s[5].c);
		if (cmp_s[5].dir.xzero && cmp_s[5].dir.yzero) begin
			brg = brq_pkg::BRG_NORTH;
		end else if (cmp_s[5].dir.xzero) begin
			brg = cmp_s[5].dir.yneg ? brq_pkg::BRG_NORTH : brq_pkg::BRG_SOUTH;
		end else if (cmp_s[5].dir.yzero) begin
			brg = cmp_s[5].dir.xneg ? brq_pkg::BRG_WEST : brq_pkg::BRG_EAST;
		end else if (!cmp_s[5].dir.xneg) begin
			brg = cmp_s[5].dir.yneg ? 9'(f) : (brq_pkg::BRG_SOUTH - 9'(f));
		end else begin
			brg = cmp_s[5].dir.yneg ? (brq_pkg::BRG_FULL - 9'(f)) : (brq_pkg::BRG_SOUTH + 9'(f));
		end
	end

	always_ff @(posedge clk) begin
		if (load[BRG_STAGE]) begin
			brg_s[BRG_STAGE] <= brg;
			same_s[BRG_STAGE] <= cmp_s[5].dir.xzero && cmp_s[5].dir.yzero;
		end
	end

	for (genvar k = BRG_STAGE + 1; k < STAGES; k++) begin : g_pad
		always_ff @(posedge clk) begin
			if (load[k]) begin
				brg_s[k] <= brg_s[k-1];
				same_s[k] <= same_s[k-1];
			end
		end
	end

	assign bearing = brg_s[STAGES-1];
	assign same = same_s[STAGES-1];

endmodule

>>> rtl/brq_sqrt.sv
module brq_sqrt #(
	parameter int COORD_BITS = 16,
	parameter int STAGES = 17
) (
	input  logic                      clk,
	input  logic [STAGES-1:0]         load,
	input  logic [2*COORD_BITS+1:0]   sumsq,
	output logic [COORD_BITS:0]       root
);

	localparam int RB = COORD_BITS + 1;
	localparam int NW = 2 * RB;

	logic [NW-1:0] rem_s [RB-1];
	logic [RB-1:0] root_s [STAGES];

	// one result bit per stage, most significant first
	for (genvar i = 0; i < RB; i++) begin : g_bit
		localparam int B = RB - 1 - i;
		logic [NW-1:0] rin, trial;
		logic [RB-1:0] rtin;
		logic ge;

		if (i == 0) begin : g_first
			assign rin = sumsq;
			assign rtin = '0;
		end else begin : g_next
			assign rin = rem_s[i-1];
			assign rtin = root_s[i-1];
		end

		assign trial = (NW'(rtin) << (B + 1)) | (NW'(1) << (2 * B));
		assign ge = (rin >= trial);

		always_ff @(posedge clk) begin
			if (load[i]) begin
				root_s[i] <= ge ? (rtin | (RB'(1) << B)) : rtin;
			end
		end

		if (i < RB - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (load[i]) begin
					rem_s[i] <= ge ? (rin - trial) : rin;
				end
			end
		end
	end

	for (genvar k = RB; k < STAGES; k++) begin : g_pad
		always_ff @(posedge clk) begin
			if (load[k]) begin
				root_s[k] <= root_s[k-1];
			end
		end
	end

	assign root = root_s[STAGES-1];

endmodule

>>> rtl/bearing_and_range_quantizer_core.sv
// an item passes the front stages, the square-root and angle stages, then the output register
// throughput: one item per cycle while result_stall is low; every stage holds its own valid bit and moves up
// when the stage after it is empty or moving, so bubbles close under result_stall
// depth is set by the square root, one result bit per stage, and the six-step arctangent search
// reset: arst_n clears all valid bits at once and sets max_range to 255
module bearing_and_range_quantizer_core #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [16:0]                   cfg_wr_data,
	input  logic                          pair_valid,
	output logic                          pair_stall,
	input  logic signed [COORD_BITS-1:0]  origin_x,
	input  logic signed [COORD_BITS-1:0]  origin_y,
	input  logic signed [COORD_BITS-1:0]  target_x,
	input  logic signed [COORD_BITS-1:0]  target_y,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [16:0]                   range_value,
	output logic [8:0]                    bearing_deg,
	output logic [3:0]                    clock_hour,
	output logic [3:0]                    range_bucket,
	output logic                          in_range
);

	localparam int RB = COORD_BITS + 1;
	localparam int CORE = (RB > brq_pkg::ANG_STAGES) ? RB : brq_pkg::ANG_STAGES;
	localparam int LAST = CORE + 4;

	logic [LAST:1] load;
	logic [LAST:1] vld_s;
	logic [16:0] max_range_q;

	logic [2*COORD_BITS+1:0] sumsq;
	logic [COORD_BITS+30:0] ps, pb;
	logic [COORD_BITS:0] big;
	logic caseb;
	brq_pkg::dir_t dir;

	logic [8:0] brg;
	logic same;
	logic [RB-1:0] root;
	logic [brq_pkg::DIST_W-1:0] range_full;

	logic [16:0] range_s_out;
	logic [8:0] bearing_s_out;
	logic [3:0] hour_s_out;
	logic [3:0] bucket_s_out;
	logic in_range_s_out;

	assign load[LAST] = !vld_s[LAST] || !result_stall;
	for (genvar i = 1; i < LAST; i++) begin : g_load
		assign load[i] = !vld_s[i] || load[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[1] <= 1'b0;
		end else if (load[1]) begin
			vld_s[1] <= pair_valid;
		end
	end

	for (genvar i = 2; i <= LAST; i++) begin : g_vld
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (load[i]) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_range_q <= 17'd255;
		end else if (cfg_wr_en) begin
			max_range_q <= cfg_wr_data;
		end
	end

	brq_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk(clk),
		.load(load[3:1]),
		.origin_x(origin_x),
		.origin_y(origin_y),
		.target_x(target_x),
		.target_y(target_y),
		.sumsq(sumsq),
		.ps(ps),
		.pb(pb),
		.big(big),
		.caseb(caseb),
		.dir(dir)
	);

	brq_angle #(
		.COORD_BITS(COORD_BITS),
		.STAGES(CORE)
	) u_angle (
		.clk(clk),
		.load(load[LAST-1:4]),
		.ps_in(ps),
		.pb_in(pb),
		.big_in(big),
		.caseb_in(caseb),
		.dir_in(dir),
		.bearing(brg),
		.same(same)
	);

	brq_sqrt #(
		.COORD_BITS(COORD_BITS),
		.STAGES(CORE)
	) u_sqrt (
		.clk(clk),
		.load(load[LAST-1:4]),
		.sumsq(sumsq),
		.root(root)
	);

	assign range_full = brq_pkg::DIST_W'(root);

	always_ff @(posedge clk) begin
		if (load[LAST]) begin
			range_s_out <= (range_full > brq_pkg::DIST_W'(brq_pkg::RANGE_SAT)) ?
				brq_pkg::RANGE_SAT : range_full[16:0];
			bearing_s_out <= brg;
			hour_s_out <= brq_pkg::hour_of(brg, same);
			bucket_s_out <= brq_pkg::bucket_of(range_full);
			in_range_s_out <= (range_full <= brq_pkg::DIST_W'(max_range_q));
		end
	end

	assign pair_stall = !load[1];
	assign result_valid = vld_s[LAST];
	assign range_value = range_s_out;
	assign bearing_deg = bearing_s_out;
	assign clock_hour = hour_s_out;
	assign range_bucket = bucket_s_out;
	assign in_range = in_range_s_out;

endmodule

>>> rtl/brq_checker.sv
module brq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic [16:0] range_value,
	input logic [8:0]  bearing_deg,
	input logic [3:0]  clock_hour,
	input logic [3:0]  range_bucket,
	input logic        in_range
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result item dropped while stalled");

	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(range_value) && $stable(bearing_deg) &&
			$stable(clock_hour) && $stable(range_bucket) && $stable(in_range))
		else $error("stalled result item changed");

	a_same_point: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((clock_hour == brq_pkg::HOUR_SAME) == (range_value == 17'd0)) &&
			((range_bucket == brq_pkg::BUCKET_NEAR) == (range_value <= 17'd1)))
		else $error("coincidence or near bucket disagrees with range");

	a_hour_north: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && clock_hour != brq_pkg::HOUR_SAME |->
			((bearing_deg < brq_pkg::SECTOR_DEG || bearing_deg == brq_pkg::BRG_FULL) ==
			(clock_hour == brq_pkg::HOUR_NORTH)))
		else $error("clock hour disagrees with bearing");

endmodule

bind bearing_and_range_quantizer_core brq_checker u_brq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.range_value(range_value),
	.bearing_deg(bearing_deg),
	.clock_hour(clock_hour),
	.range_bucket(range_bucket),
	.in_range(in_range)
);

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int WATCHDOG = 5000;
	localparam int PHASE_ITEMS = 190;
	localparam int DRAIN_CYCLES = 30;

	typedef struct packed {
		logic [16:0] range_value;
		logic [8:0]  bearing_deg;
		logic [3:0]  clock_hour;
		logic [3:0]  range_bucket;
		logic        in_range;
	} fix_t;

	class fix_scoreboard;
		fix_t fixes_due[$];
		longint unsigned tan_e9[46];
		int unsigned step_lim[10];
		logic [16:0] max_range;
		int unsigned fails;

		function new();
			tan_e9 = '{
				0, 17455065, 34920769, 52407779, 69926812, 87488664,
				105104235, 122784561, 140540835, 158384440, 176326981,
				194380309, 212556562, 230868191, 249328003, 267949192,
				286745386, 305730681, 324919696, 344327613, 363970234,
				383864035, 404026226, 424474816, 445228685, 466307658,
				487732589, 509525449, 531709432, 554309051, 577350269,
				600860619, 624869352, 649407593, 674508517, 700207538,
				726542528, 753554050, 781285627, 809784033, 839099631,
				869286738, 900404044, 932515086, 965688775, 1000000000
			};
			step_lim = '{200, 150, 100, 75, 50, 25, 15, 10, 5, 1};
			max_range = 17'd255;
			fails = 0;
		endfunction

		function void complain(input string msg);
			fails++;
			if (fails <= 10) begin
				$display("%0t ns: %s", $realtime, msg);
			end
		endfunction

		function void note_pair(input logic signed [15:0] ox, oy, tx, ty);
			longint sx, sy;
			longint unsigned ax, ay, rem, root, probe, range_full, one_e9;
			int unsigned ang, brg, bkt;
			fix_t e;
			one_e9 = 1000000000;
			sx = longint'(tx) - longint'(ox);
			sy = longint'(ty) - longint'(oy);
			ax = sx < 0 ? -sx : sx;
			ay = sy < 0 ? -sy : sy;
			// bitwise integer square root
			rem = ax * ax + ay * ay;
			root = 0;
			probe = 64'd1 << 62;
			while (probe > rem) probe >>= 2;
			while (probe != 0) begin
				if (rem >= root + probe) begin
					rem -= root + probe;
					root = (root >> 1) + probe;
				end else begin
					root >>= 1;
				end
				probe >>= 2;
			end
			range_full = root;
			// truncated angle off the north-south line
			ang = 0;
			if (ax != 0 && ay != 0) begin
				for (int d = 1; d <= 89; d++) begin
					if (d <= 45) begin
						if (ax * one_e9 >= ay * tan_e9[d]) ang++;
					end else begin
						if (ay * one_e9 <= ax * tan_e9[90 - d]) ang++;
					end
				end
			end
			if (sx == 0 && sy == 0) brg = 0;
			else if (sx == 0) brg = sy > 0 ? 180 : 0;
			else if (sy == 0) brg = sx > 0 ? 90 : 270;
			else if (sx > 0) brg = sy < 0 ? ang : 180 - ang;
			else brg = sy > 0 ? 180 + ang : 360 - ang;
			bkt = brq_pkg::BUCKET_NEAR;
			for (int i = 9; i >= 0; i--) begin
				if (range_full > step_lim[i]) bkt = i;
			end
			e.range_value = range_full > 131071 ? brq_pkg::RANGE_SAT : 17'(range_full);
			e.bearing_deg = 9'(brg);
			if (sx == 0 && sy == 0) e.clock_hour = brq_pkg::HOUR_SAME;
			else if (brg < 30 || brg >= 360) e.clock_hour = brq_pkg::HOUR_NORTH;
			else e.clock_hour = 4'(brg / 30);
			e.range_bucket = 4'(bkt);
			e.in_range = range_full <= longint'(max_range);
			fixes_due.push_back(e);
		endfunction

		function void check_result(input fix_t got);
			fix_t e;
			if (fixes_due.size() == 0) begin
				complain($sformatf("unexpected result range %0d bearing %0d",
					got.range_value, got.bearing_deg));
				return;
			end
			e = fixes_due.pop_front();
			if (got != e) begin
				complain($sformatf({"mismatch exp range %0d brg %0d hour %0d bkt %0d in %0d,",
					" got range %0d brg %0d hour %0d bkt %0d in %0d"},
					e.range_value, e.bearing_deg, e.clock_hour, e.range_bucket, e.in_range,
					got.range_value, got.bearing_deg, got.clock_hour, got.range_bucket,
					got.in_range));
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [16:0] cfg_wr_data = '0;
	logic pair_valid = 1'b0;
	logic pair_stall;
	logic signed [15:0] origin_x = '0;
	logic signed [15:0] origin_y = '0;
	logic signed [15:0] target_x = '0;
	logic signed [15:0] target_y = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [16:0] range_value;
	logic [8:0] bearing_deg;
	logic [3:0] clock_hour;
	logic [3:0] range_bucket;
	logic in_range;

	logic no_gaps = 1'b0;
	int quiet_cycles = 0;
	fix_scoreboard sb;

	bearing_and_range_quantizer_core #(
		.COORD_BITS(16)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.pair_valid(pair_valid),
		.pair_stall(pair_stall),
		.origin_x(origin_x),
		.origin_y(origin_y),
		.target_x(target_x),
		.target_y(target_y),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.range_value(range_value),
		.bearing_deg(bearing_deg),
		.clock_hour(clock_hour),
		.range_bucket(range_bucket),
		.in_range(in_range)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			sb.check_result({range_value, bearing_deg, clock_hour, range_bucket, in_range});
		end
		if (arst_n && ((pair_valid && !pair_stall) || (result_valid && !result_stall)))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		result_stall <= !no_gaps && ($urandom_range(99) < 37);
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG);
		$display("tb: failure");
		$finish;
	end

	task automatic send_pair(input logic signed [15:0] ox, oy, tx, ty);
		while (!no_gaps && $urandom_range(99) < 37) begin
			pair_valid <= 1'b0;
			@(posedge clk);
		end
		pair_valid <= 1'b1;
		origin_x <= ox;
		origin_y <= oy;
		target_x <= tx;
		target_y <= ty;
		do @(posedge clk); while (pair_stall);
		sb.note_pair(ox, oy, tx, ty);
	endtask

	task automatic drain();
		pair_valid <= 1'b0;
		do @(posedge clk); while (sb.fixes_due.size() != 0);
	endtask

	task automatic write_limit(input logic [16:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.max_range = v;
	endtask

	task automatic random_pair();
		logic signed [15:0] ox, oy;
		int dx, dy, mode, mag;
		ox = 16'($urandom);
		oy = 16'($urandom);
		mode = $urandom_range(99);
		if (mode < 30) begin
			send_pair(ox, oy, 16'($urandom), 16'($urandom));
			return;
		end
		if (mode < 70) begin
			dx = $urandom_range(360) - 180;
			dy = $urandom_range(360) - 180;
		end else if (mode < 80) begin
			dx = $urandom_range(24) - 12;
			dy = $urandom_range(24) - 12;
		end else if (mode < 88) begin
			mag = int'($urandom_range(65535) >> $urandom_range(15));
			dx = $urandom_range(1) ? mag : -mag;
			dy = 0;
			if ($urandom_range(1)) begin
				dy = dx;
				dx = 0;
			end
		end else if (mode < 94) begin
			mag = int'($urandom_range(32767) >> $urandom_range(14));
			dx = $urandom_range(1) ? mag : -mag;
			dy = $urandom_range(1) ? mag : -mag;
		end else begin
			dx = 0;
			dy = 0;
		end
		send_pair(ox, oy, 16'(int'(ox) + dx), 16'(int'(oy) + dy));
	endtask

	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limit of 255 still in force
		send_pair(0, 0, 0, 0);
		send_pair(5, 5, 5, 5);
		send_pair(-32768, -32768, 32767, 32767);
		send_pair(32767, 32767, -32768, -32768);
		send_pair(-32768, 32767, 32767, -32768);
		send_pair(32767, -32768, -32768, 32767);
		send_pair(-32768, 0, 32767, 0);
		send_pair(0, 0, 0, -5);
		send_pair(0, 0, 7, 0);
		send_pair(0, 0, 0, 9);
		send_pair(0, 0, -3, 0);
		send_pair(0, 0, -1, -100);
		send_pair(0, 0, 1, -100);
		send_pair(0, 0, 100, 1);
		send_pair(0, 0, -100, 1);
		send_pair(0, 0, 10, -10);
		send_pair(0, 0, 1000, -1732);
		send_pair(0, 0, 1000, -1731);
		send_pair(100, 100, 300, 100);
		send_pair(0, 0, 201, 0);
		send_pair(0, 0, 1, 1);
		send_pair(0, 0, 2, 0);
		send_pair(0, 0, 3, 4);
		send_pair(0, 0, 6, 8);
		send_pair(0, 0, 0, -255);
		send_pair(0, 0, 0, -256);

		for (int ph = 0; ph < 5; ph++) begin
			drain();
			case (ph)
				0: write_limit(17'd0);
				1: write_limit(17'h1FFFF);
				2: write_limit(17'($urandom_range(300)));
				3: write_limit(17'($urandom));
				default: write_limit(17'($urandom_range(100)));
			endcase
			// in phase 1, a long stretch with both sides busy every cycle
			no_gaps <= (ph == 1);
			for (int n = 0; n < PHASE_ITEMS; n++) random_pair();
			no_gaps <= 1'b0;
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.fails == 0 && sb.fixes_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
